>>> rtl/core/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg - shared definitions for the character LCD text writer
// Display geometry, bus command bytes, control codes and the item decode.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

  // Display geometry
  localparam int unsigned LINE_LENGTH = 40;
  localparam int unsigned LINE_OFFSET = 64;

  localparam logic [6:0] LINE_LEN_C = 7'(LINE_LENGTH);
  localparam logic [6:0] LINE_OFS_C = 7'(LINE_OFFSET);

  // Bus command and data bytes
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  // Control character codes
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_RETURN    = 8'd13;
  localparam logic [7:0] CODE_CLEAR     = 8'd127;

  // Register-select values
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Index of the final nibble of each sequence
  localparam logic [4:0] LAST_SHORT = 5'd1;
  localparam logic [4:0] LAST_BACK  = 5'd5;
  localparam logic [4:0] LAST_GLYPH = 5'd21;

  typedef enum logic [2:0] {
    OP_DATA      = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_RETURN    = 3'd2,
    OP_BACKSPACE = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_GLYPH     = 3'd5
  } op_e;

  // Set-DDRAM command byte for a cursor position
  function automatic logic [7:0] ddram_cmd(logic [5:0] col, logic ln);
    logic [6:0] addr;
    addr = (ln ? LINE_OFS_C : 7'd0) + {1'b0, col};
    return CMD_SET_DDRAM | {1'b0, addr};
  endfunction

  function automatic logic [4:0] last_nibble(op_e op);
    logic [4:0] idx;
    case (op)
      OP_BACKSPACE: idx = LAST_BACK;
      OP_GLYPH:     idx = LAST_GLYPH;
      default:      idx = LAST_SHORT;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lcdw_if.sv
// ----------------------------------------------------------------------------
// lcdw_if - valid/ready channels of the character LCD text writer
// Item channel (characters and glyph definitions) and nibble channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdw_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  logic [2:0] glyph_slot;
  logic [7:0] row0;
  logic [7:0] row1;
  logic [7:0] row2;
  logic [7:0] row3;
  logic [7:0] row4;
  logic [7:0] row5;
  logic [7:0] row6;
  logic [7:0] row7;

  modport source (
    output valid, kind, char_code, glyph_slot,
           row0, row1, row2, row3, row4, row5, row6, row7,
    input  ready
  );
  modport sink (
    input  valid, kind, char_code, glyph_slot,
           row0, row1, row2, row3, row4, row5, row6, row7,
    output ready
  );
endinterface

interface lcdw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       reg_select;
  logic       last;
  logic [5:0] cursor_column;
  logic       cursor_line;

  modport source (
    output valid, nibble, reg_select, last, cursor_column, cursor_line,
    input  ready
  );
  modport sink (
    input  valid, nibble, reg_select, last, cursor_column, cursor_line,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/char_lcd_text_writer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_text_writer_top - 4-bit character LCD text writer
// Turns characters and glyph definitions into bus nibbles with register select.
// ----------------------------------------------------------------------------
// Usage
//   item_i carries one word per character or per glyph definition. kind 0
//   prints char_code (newline, return, backspace and code 127 are turned into
//   cursor commands or clear); kind 1 writes rows 0..7 to the CGRAM slot,
//   puts the cursor back and prints the glyph.
//   nib_o carries one bus nibble per word, high nibble first, with the
//   register-select bit, a last flag on the final nibble of an item and the
//   tracked cursor after that item.
// Pipeline and throughput
//   A taken item is held in the item stage; its nibbles reach nib_o through
//   the output register. The single nibble bus sets the rate: one nibble per
//   cycle while ready is high; an item is 2 nibbles (plain character, newline,
//   return, clear), 6 (backspace) or 22 (glyph). The next item is taken in the
//   cycle the final nibble of the current one moves to the output register.
// Reset and stalls
//   Reset homes the cursor to column 0, line 0 and empties both stages.
//   When the receiver holds ready low the output word holds, the item stage
//   holds its place and item_i.ready drops once the item stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_text_writer_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lcdw_in_if.sink    item_i,
  lcdw_out_if.source nib_o
);

  // Tracked cursor, updated when an item is taken
  logic [5:0] col_q;
  logic       line_q;

  // Item stage
  logic            item_vld_q;
  logic [4:0]      idx_q;
  lcdw_pkg::op_e   op_q, op_d;
  logic [7:0]      code_q;
  logic [2:0]      slot_q;
  logic [7:0]      rows_q [8];
  logic [7:0]      cmd_a_q, cmd_a_d;
  logic [7:0]      cmd_b_q, cmd_b_d;
  logic [5:0]      ncol_q, ncol_d;
  logic            nline_q, nline_d;

  // Output register
  logic       out_vld_q;
  logic [3:0] out_nib_q;
  logic       out_rs_q;
  logic       out_last_q;
  logic [5:0] out_col_q;
  logic       out_line_q;

  logic out_load, item_step, item_done, accept;
  logic is_last;

  assign out_load  = !out_vld_q || nib_o.ready;
  assign item_step = item_vld_q && out_load;
  assign is_last   = (idx_q == lcdw_pkg::last_nibble(op_q));
  assign item_done = item_step && is_last;

  assign item_i.ready = !item_vld_q || item_done;
  assign accept       = item_i.valid && item_i.ready;

  // --------------------------------------------------------------------------
  // Decode the item and work out the cursor moves it makes
  // --------------------------------------------------------------------------
  logic [5:0] adv_col, back_col, adv2_col, back2_col;
  logic       adv_line, adv2_line;

  always_comb begin
    // Advance from the current cursor (data write)
    if ({1'b0, col_q} + 7'd1 >= lcdw_pkg::LINE_LEN_C) begin
      adv_col  = '0;
      adv_line = !line_q;
    end else begin
      adv_col  = col_q + 6'd1;
      adv_line = line_q;
    end
    // Backspace: step back, write a space, step back again
    back_col = (col_q == '0) ? '0 : col_q - 6'd1;
    if ({1'b0, back_col} + 7'd1 >= lcdw_pkg::LINE_LEN_C) begin
      adv2_col  = '0;
      adv2_line = !line_q;
    end else begin
      adv2_col  = back_col + 6'd1;
      adv2_line = line_q;
    end
    back2_col = (adv2_col == '0) ? '0 : adv2_col - 6'd1;
  end

  always_comb begin
    op_d    = lcdw_pkg::OP_DATA;
    cmd_a_d = lcdw_pkg::ddram_cmd(col_q, line_q);
    cmd_b_d = cmd_a_d;
    ncol_d  = adv_col;
    nline_d = adv_line;
    if (item_i.kind) begin
      op_d = lcdw_pkg::OP_GLYPH;
    end else begin
      case (item_i.char_code)
        lcdw_pkg::CODE_NEWLINE: begin
          op_d    = lcdw_pkg::OP_NEWLINE;
          ncol_d  = col_q;
          nline_d = !line_q;
          cmd_a_d = lcdw_pkg::ddram_cmd(col_q, !line_q);
        end
        lcdw_pkg::CODE_RETURN: begin
          op_d    = lcdw_pkg::OP_RETURN;
          ncol_d  = '0;
          nline_d = line_q;
          cmd_a_d = lcdw_pkg::ddram_cmd('0, line_q);
        end
        lcdw_pkg::CODE_BACKSPACE: begin
          op_d    = lcdw_pkg::OP_BACKSPACE;
          cmd_a_d = lcdw_pkg::ddram_cmd(back_col, line_q);
          cmd_b_d = lcdw_pkg::ddram_cmd(back2_col, adv2_line);
          ncol_d  = back2_col;
          nline_d = adv2_line;
        end
        lcdw_pkg::CODE_CLEAR: begin
          op_d    = lcdw_pkg::OP_CLEAR;
          ncol_d  = '0;
          nline_d = 1'b0;
        end
        default: begin
          op_d = lcdw_pkg::OP_DATA;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pick the byte and nibble for the current step of the item
  // --------------------------------------------------------------------------
  logic [3:0] byte_idx, row_sel;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic [3:0] cur_nib;

  assign byte_idx = idx_q[4:1];
  assign row_sel  = byte_idx - 4'd1;

  always_comb begin
    cur_byte = code_q;
    cur_rs   = lcdw_pkg::RS_DATA;
    case (op_q)
      lcdw_pkg::OP_DATA: begin
        cur_byte = code_q;
        cur_rs   = lcdw_pkg::RS_DATA;
      end
      lcdw_pkg::OP_NEWLINE,
      lcdw_pkg::OP_RETURN: begin
        cur_byte = cmd_a_q;
        cur_rs   = lcdw_pkg::RS_CMD;
      end
      lcdw_pkg::OP_CLEAR: begin
        cur_byte = lcdw_pkg::CMD_CLEAR;
        cur_rs   = lcdw_pkg::RS_CMD;
      end
      lcdw_pkg::OP_BACKSPACE: begin
        if (byte_idx == 4'd0) begin
          cur_byte = cmd_a_q;
          cur_rs   = lcdw_pkg::RS_CMD;
        end else if (byte_idx == 4'd1) begin
          cur_byte = lcdw_pkg::CHAR_SPACE;
          cur_rs   = lcdw_pkg::RS_DATA;
        end else begin
          cur_byte = cmd_b_q;
          cur_rs   = lcdw_pkg::RS_CMD;
        end
      end
      lcdw_pkg::OP_GLYPH: begin
        if (byte_idx == 4'd0) begin
          cur_byte = lcdw_pkg::CMD_SET_CGRAM | {2'b00, slot_q, 3'b000};
          cur_rs   = lcdw_pkg::RS_CMD;
        end else if (byte_idx == 4'd9) begin
          cur_byte = cmd_a_q;
          cur_rs   = lcdw_pkg::RS_CMD;
        end else if (byte_idx == 4'd10) begin
          cur_byte = {5'b00000, slot_q};
          cur_rs   = lcdw_pkg::RS_DATA;
        end else begin
          cur_byte = rows_q[row_sel[2:0]];
          cur_rs   = lcdw_pkg::RS_DATA;
        end
      end
      default: begin
        cur_byte = code_q;
        cur_rs   = lcdw_pkg::RS_DATA;
      end
    endcase
    cur_nib = idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      line_q     <= 1'b0;
      item_vld_q <= 1'b0;
      idx_q      <= '0;
      op_q       <= lcdw_pkg::OP_DATA;
      out_vld_q  <= 1'b0;
    end else begin
      // take a new item and move the cursor
      if (accept) begin
        item_vld_q <= 1'b1;
        idx_q      <= '0;
        op_q       <= op_d;
        col_q      <= ncol_d;
        line_q     <= nline_d;
      end else if (item_step) begin
        // advance through the item, drop it after its final nibble
        if (is_last) begin
          item_vld_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 5'd1;
        end
      end
      if (out_load) begin
        out_vld_q <= item_vld_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q    <= item_i.char_code;
      slot_q    <= item_i.glyph_slot;
      rows_q[0] <= item_i.row0;
      rows_q[1] <= item_i.row1;
      rows_q[2] <= item_i.row2;
      rows_q[3] <= item_i.row3;
      rows_q[4] <= item_i.row4;
      rows_q[5] <= item_i.row5;
      rows_q[6] <= item_i.row6;
      rows_q[7] <= item_i.row7;
      cmd_a_q   <= cmd_a_d;
      cmd_b_q   <= cmd_b_d;
      ncol_q    <= ncol_d;
      nline_q   <= nline_d;
    end
    if (item_step) begin
      out_nib_q  <= cur_nib;
      out_rs_q   <= cur_rs;
      out_last_q <= is_last;
      out_col_q  <= ncol_q;
      out_line_q <= nline_q;
    end
  end

  assign nib_o.valid         = out_vld_q;
  assign nib_o.nibble        = out_nib_q;
  assign nib_o.reg_select    = out_rs_q;
  assign nib_o.last          = out_last_q;
  assign nib_o.cursor_column = out_col_q;
  assign nib_o.cursor_line   = out_line_q;

endmodule

`default_nettype wire

>>> rtl/core/lcdw_checker.sv
// ----------------------------------------------------------------------------
// lcdw_checker - port-level checks for the character LCD text writer
// Watches the nibble channel; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_i,
  input wire logic       ready_i,
  input wire logic       last_i,
  input wire logic [5:0] cursor_column_i,
  input wire logic       cursor_line_i
);

  // A stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("nibble word dropped while stalled");

  // Nibbles of one item follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && !last_i |=> valid_i)
    else $error("gap inside a nibble sequence");

  // The reported cursor is the same for every nibble of an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && !last_i |=>
      cursor_column_i == $past(cursor_column_i) &&
      cursor_line_i == $past(cursor_line_i))
    else $error("cursor changed inside an item");

  // The tracked column stays on the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> {1'b0, cursor_column_i} < lcdw_pkg::LINE_LEN_C)
    else $error("cursor column beyond line length");

endmodule

bind char_lcd_text_writer_top lcdw_checker u_lcdw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (nib_o.valid),
  .ready_i        (nib_o.ready),
  .last_i         (nib_o.last),
  .cursor_column_i(nib_o.cursor_column),
  .cursor_line_i  (nib_o.cursor_line)
);

`default_nettype wire
